// ===== rtl/asp_pkg.sv =====
package asp_pkg;

  // Report layout
  localparam int unsigned REPORT_BYTES = 6;
  localparam int unsigned HALVES       = 2 * REPORT_BYTES;
  localparam int unsigned HALF_W       = $clog2(HALVES);
  localparam int unsigned BYTE_SEL_W   = $clog2(REPORT_BYTES);

  // Timing
  localparam int unsigned PREWAIT_UNITS_DEF = 5;
  localparam int unsigned CNT_W             = 15;

  localparam logic [CNT_W-1:0] RST_PULSE_TIMEOUT = CNT_W'(150);
  localparam logic [CNT_W-1:0] RST_PULSE_MINIMUM = CNT_W'(10);

  // Pins while idle
  localparam logic [3:0] IDLE_NIBBLE = 4'hf;

  typedef enum logic {
    CFG_PULSE_TIMEOUT = 1'b0,
    CFG_PULSE_MINIMUM = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MEASURE = 5'b00010,
    ST_PREWAIT = 5'b00100,
    ST_SEND    = 5'b01000,
    ST_TAIL    = 5'b10000
  } seq_state_e;

  typedef struct packed {
    logic       action;
    logic       request_level;
    logic [15:0] buttons;
    logic [7:0] axis_zero;
    logic [7:0] axis_one;
    logic [7:0] axis_two;
    logic [7:0] axis_three;
  } in_item_t;

  typedef struct packed {
    logic [3:0] data_nibble;
    logic       phase_high;
    logic       ready_n;
    logic       busy_res;
    logic       suspended;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] pulse_timeout;
    logic [CNT_W-1:0] pulse_minimum;
  } cfg_t;

  typedef logic [REPORT_BYTES-1:0][7:0] report_t;

  // Buttons are active high on input, inverted on the wire.
  function automatic report_t pack_report(in_item_t it);
    logic [15:0] d;
    logic [7:0]  d0;
    logic [7:0]  d1;
    report_t     r;
    d    = ~it.buttons;
    d0   = d[15:8];
    d1   = d[7:0];
    r[0] = {d0[1:0] & d1[3:2], d1[7:4], d0[7:6]};
    r[1] = {it.axis_zero[7:4], it.axis_one[7:4]};
    r[2] = {it.axis_two[7:4], it.axis_three[7:4]};
    r[3] = {it.axis_zero[3:0], it.axis_one[3:0]};
    r[4] = {it.axis_two[3:0], it.axis_three[3:0]};
    r[5] = {d0[1:0], d1[3:2], 4'hf};
    return r;
  endfunction

endpackage

// ===== rtl/asp_if.sv =====
interface asp_cfg_if import asp_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_e         index;
  logic [CNT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface asp_in_if import asp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        action;
  logic        request_level;
  logic [15:0] buttons;
  logic [7:0]  axis_zero;
  logic [7:0]  axis_one;
  logic [7:0]  axis_two;
  logic [7:0]  axis_three;

  modport source (output valid, action, request_level, buttons, axis_zero, axis_one,
                  axis_two, axis_three, input ready);
  modport sink   (input valid, action, request_level, buttons, axis_zero, axis_one,
                  axis_two, axis_three, output ready);
endinterface

interface asp_out_if import asp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       phase_high;
  logic       ready_n;
  logic       busy_res;
  logic       suspended;

  modport source (output valid, data_nibble, phase_high, ready_n, busy_res, suspended,
                  input ready);
  modport sink   (input valid, data_nibble, phase_high, ready_n, busy_res, suspended,
                  output ready);
endinterface

// ===== rtl/asp_report.sv =====
module asp_report import asp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  in_item_t              item_i,
  input  logic [BYTE_SEL_W-1:0] rd_sel_i,
  output logic [7:0]            rd_byte_o
);

  report_t store_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '1;
    end else if (load_i) begin
      store_q <= pack_report(item_i);
    end
  end

  assign rd_byte_o = (rd_sel_i < BYTE_SEL_W'(REPORT_BYTES)) ? store_q[rd_sel_i] : 8'hff;

endmodule

// ===== rtl/asp_seq.sv =====
module asp_seq import asp_pkg::*; #(
  parameter int unsigned PREWAIT_UNITS = PREWAIT_UNITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  in_item_t              item_i,
  input  cfg_t                  cfg_i,
  input  logic [7:0]            rd_byte_i,
  output logic [BYTE_SEL_W-1:0] rd_sel_o,
  output result_t               result_o
);

  // wide enough for unit * PREWAIT_UNITS and, when PREWAIT_UNITS is at least 1, for unit * 2
  localparam int unsigned WAIT_W = CNT_W + $clog2(PREWAIT_UNITS + 1);

  seq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [HALF_W-1:0] half_q, half_d;
  logic [3:0]        data_q, data_d;
  logic              phase_q, phase_d;
  logic              rdyn_q, rdyn_d;
  logic              susp_q, susp_d;

  logic              show_en;
  logic [HALF_W-1:0] show_half;
  logic [HALF_W-1:0] half_inc;
  logic [WAIT_W-1:0] wait_dec;
  logic [CNT_W-1:0]  cnt_min;
  logic [CNT_W-1:0]  cnt_clamp;
  logic [CNT_W-1:0]  cnt_inc;

  assign wait_dec  = (wait_q != '0) ? wait_q - WAIT_W'(1) : '0;
  assign cnt_min   = (cfg_i.pulse_minimum == '0) ? CNT_W'(1) : cfg_i.pulse_minimum;
  assign cnt_clamp = (cnt_q < cfg_i.pulse_minimum) ?
                     ((cfg_i.pulse_minimum == '0) ? CNT_W'(1) : cfg_i.pulse_minimum) :
                     ((cnt_q == '0) ? CNT_W'(1) : cnt_q);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign half_inc  = half_q + HALF_W'(1);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    wait_d    = wait_q;
    half_d    = half_q;
    data_d    = data_q;
    phase_d   = phase_q;
    rdyn_d    = rdyn_q;
    susp_d    = susp_q;
    show_en   = 1'b0;
    show_half = '0;

    if (item_i.action) begin
      susp_d = 1'b0;
    end else begin
      case (state_q)
        ST_MEASURE: begin
          if (cnt_q >= cfg_i.pulse_timeout ||
              (!item_i.request_level && cnt_inc >= cfg_i.pulse_timeout)) begin
            // give up: minimum unit, no prewait, suspend
            cnt_d   = cnt_min;
            susp_d  = 1'b1;
            state_d = ST_SEND;
            half_d  = '0;
            show_en = 1'b1;
            wait_d  = WAIT_W'(cnt_min);
          end else if (item_i.request_level) begin
            cnt_d   = cnt_clamp;
            wait_d  = WAIT_W'(cnt_clamp) * WAIT_W'(PREWAIT_UNITS);
            state_d = ST_PREWAIT;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        ST_PREWAIT: begin
          wait_d = wait_dec;
          if (wait_dec == '0) begin
            state_d = ST_SEND;
            half_d  = '0;
            show_en = 1'b1;
            wait_d  = WAIT_W'(cnt_q);
          end
        end
        ST_SEND: begin
          wait_d = wait_dec;
          if (wait_dec == '0) begin
            if (rdyn_q) begin
              rdyn_d = 1'b0;
              wait_d = WAIT_W'({cnt_q, 1'b0});
            end else begin
              rdyn_d = 1'b1;
              wait_d = WAIT_W'(cnt_q);
              if (half_inc < HALF_W'(HALVES)) begin
                half_d    = half_inc;
                show_en   = 1'b1;
                show_half = half_inc;
              end else begin
                half_d  = '0;
                state_d = ST_TAIL;
              end
            end
          end
        end
        ST_TAIL: begin
          wait_d = wait_dec;
          if (wait_dec == '0) begin
            data_d  = IDLE_NIBBLE;
            phase_d = 1'b0;
            rdyn_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
          if (!susp_q && !item_i.request_level) begin
            cnt_d   = '0;
            state_d = ST_MEASURE;
          end
        end
      endcase

      if (show_en) begin
        data_d  = show_half[0] ? rd_byte_i[3:0] : rd_byte_i[7:4];
        phase_d = show_half[0];
        rdyn_d  = 1'b1;
      end
    end
  end

  assign rd_sel_o = BYTE_SEL_W'(show_half >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      wait_q  <= '0;
      half_q  <= '0;
      data_q  <= IDLE_NIBBLE;
      phase_q <= 1'b0;
      rdyn_q  <= 1'b1;
      susp_q  <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
      half_q  <= half_d;
      data_q  <= data_d;
      phase_q <= phase_d;
      rdyn_q  <= rdyn_d;
      susp_q  <= susp_d;
    end
  end

  // pins as they stand after this item
  assign result_o.data_nibble = data_d;
  assign result_o.phase_high  = phase_d;
  assign result_o.ready_n     = rdyn_d;
  assign result_o.busy_res    = (state_d != ST_IDLE);
  assign result_o.suspended   = susp_d;

endmodule

// ===== rtl/analog_stick_port_responder.sv =====
// Channel  Dir  Beat contents
// cfg_i    in   index (pulse_timeout / pulse_minimum), 15-bit data
// in_i     in   action, request_level, buttons, axis_zero..axis_three
// out_o    out  data_nibble, phase_high, ready_n, busy_res, suspended
//
// One beat in, one beat out. Two register stages: input register, then the
// result register; the sequencer state advances when an item moves between them.
// Throughput is one item per clock while out_o is not stalled. out_o.valid rises
// when an item moves from the input register into the result register.
// A stalled out_o holds the result register and backs up into the input register;
// in_i.ready drops only when both are full. cfg_i is always ready.
// Reset: report all ones, pins idle (0xf, phase 0, ready_n 1), timeout 150, minimum 10.
module analog_stick_port_responder import asp_pkg::*; #(
  parameter int unsigned PREWAIT_UNITS = PREWAIT_UNITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  asp_cfg_if.sink  cfg_i,
  asp_in_if.sink   in_i,
  asp_out_if.source out_o
);

  // configuration registers
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_timeout <= RST_PULSE_TIMEOUT;
      cfg_q.pulse_minimum <= RST_PULSE_MINIMUM;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PULSE_TIMEOUT: cfg_q.pulse_timeout <= cfg_i.data;
        CFG_PULSE_MINIMUM: cfg_q.pulse_minimum <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input register
  logic     in_valid_q;
  in_item_t in_q;
  in_item_t in_item;
  logic     out_free;
  logic     advance;

  // result register
  logic    out_valid_q;
  result_t out_q;
  result_t result;

  assign in_item.action        = in_i.action;
  assign in_item.request_level = in_i.request_level;
  assign in_item.buttons       = in_i.buttons;
  assign in_item.axis_zero     = in_i.axis_zero;
  assign in_item.axis_one      = in_i.axis_one;
  assign in_item.axis_two      = in_i.axis_two;
  assign in_item.axis_three    = in_i.axis_three;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_item;
    end
  end

  // report store and sequencer
  logic [BYTE_SEL_W-1:0] rd_sel;
  logic [7:0]            rd_byte;

  asp_report u_report (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && in_q.action),
    .item_i    (in_q),
    .rd_sel_i  (rd_sel),
    .rd_byte_o (rd_byte)
  );

  asp_seq #(
    .PREWAIT_UNITS (PREWAIT_UNITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_q),
    .cfg_i     (cfg_q),
    .rd_byte_i (rd_byte),
    .rd_sel_o  (rd_sel),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_nibble = out_q.data_nibble;
  assign out_o.phase_high  = out_q.phase_high;
  assign out_o.ready_n     = out_q.ready_n;
  assign out_o.busy_res    = out_q.busy_res;
  assign out_o.suspended   = out_q.suspended;

`ifndef NO_ASSERTIONS
  // idle means the port pins are parked
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.busy_res) |->
      (out_q.data_nibble == IDLE_NIBBLE && !out_q.phase_high && out_q.ready_n))
    else $error("idle result with pins not parked");

  // a load clears suspend in its own result
  a_load_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.action) |=> (out_valid_q && !out_q.suspended))
    else $error("load did not clear suspend");

  // a stalled input beat is never dropped
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> in_valid_q)
    else $error("input register lost a beat");
`endif

endmodule
